>>> hw/rtl/ksmsc_pkg.sv
`default_nettype none

package ksmsc_pkg;

   localparam int KEY_W       = 14;
   localparam int COST_W      = 14;
   localparam int DIGIT_W     = 4;
   localparam int DIGITS      = 4;
   localparam int BCD_W       = DIGIT_W * DIGITS;
   localparam int STEP_W      = $clog2(DIGITS);
   localparam int LINK_W      = 5;
   localparam int RECIP_W     = 13;
   localparam int RECIP_SHIFT = 16;

   localparam logic [LINK_W-1:0]  LINK_INF  = 5'd31;
   localparam logic [RECIP_W-1:0] RECIP     = 13'd6554;
   localparam logic [DIGIT_W-1:0] DIAL      = 4'd10;
   localparam logic [DIGIT_W-1:0] DIAL_HALF = 4'd5;

   typedef struct packed {
      logic [KEY_W-1:0] key_value;
      logic             last_key;
   } req_type;

   typedef struct packed {
      logic [COST_W-1:0] total_cost;
      logic              overflow;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic drop;
      logic conv_step;
      logic store;
      logic compute_begin;
      logic pass_begin;
      logic scan_issue;
      logic pass_finish;
      logic respond;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic digit_done;
      logic last;
      logic scan_last;
      logic count_le1;
      logic passes_one;
   } sts_type;

endpackage

`default_nettype wire

>>> hw/rtl/ksmsc_ram.sv
`default_nettype none

module ksmsc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                        clock,
   input  wire logic                                        wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                            wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                            rd_data
);

   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;
   logic [ADDR_W-1:0] rd_addr_chk;

   assign rd_addr_chk = rd_addr;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr_chk];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> hw/rtl/ksmsc_ctrl.sv
`default_nettype none

module ksmsc_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic               last_key,
   input  wire ksmsc_pkg::sts_type sts,
   output ksmsc_pkg::cmd_type      cmd,
   output logic                    busy,
   output logic                    rsp_valid
);

   import ksmsc_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE    = 8'b0000_0001,
      ST_CONVERT = 8'b0000_0010,
      ST_STORE   = 8'b0000_0100,
      ST_COMPUTE = 8'b0000_1000,
      ST_SCAN    = 8'b0001_0000,
      ST_DRAIN   = 8'b0010_0000,
      ST_FINISH  = 8'b0100_0000,
      ST_RESPOND = 8'b1000_0000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               if (sts.full) begin
                  cmd.drop = 1'b1;
                  state_in = last_key ? ST_COMPUTE : ST_IDLE;
               end else begin
                  state_in = ST_CONVERT;
               end
            end
         end
         ST_CONVERT: begin
            cmd.conv_step = 1'b1;
            if (sts.digit_done) begin
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            cmd.store = 1'b1;
            state_in  = sts.last ? ST_COMPUTE : ST_IDLE;
         end
         ST_COMPUTE: begin
            cmd.compute_begin = 1'b1;
            cmd.pass_begin    = 1'b1;
            state_in          = sts.count_le1 ? ST_RESPOND : ST_SCAN;
         end
         ST_SCAN: begin
            cmd.scan_issue = 1'b1;
            if (sts.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            cmd.pass_finish = 1'b1;
            cmd.pass_begin  = 1'b1;
            state_in        = sts.passes_one ? ST_RESPOND : ST_SCAN;
         end
         ST_RESPOND: begin
            cmd.respond = 1'b1;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESPOND);

endmodule

`default_nettype wire

>>> hw/rtl/ksmsc_datapath.sv
`default_nettype none

module ksmsc_datapath #(
   parameter int MAX_KEYS = 512
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire ksmsc_pkg::req_type req,
   input  wire ksmsc_pkg::cmd_type cmd,
   output ksmsc_pkg::sts_type      sts,
   output ksmsc_pkg::rsp_type      rsp
);

   import ksmsc_pkg::*;

   localparam int IDX_W  = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
   localparam int CNT_W  = $clog2(MAX_KEYS + 1);
   localparam int PROD_W = KEY_W + RECIP_W;

   function automatic logic [LINK_W-1:0] dial_dist(input logic [BCD_W-1:0] a,
                                                   input logic [BCD_W-1:0] b);
      logic [DIGIT_W-1:0] x;
      logic [DIGIT_W-1:0] y;
      logic [DIGIT_W-1:0] d;
      logic [LINK_W-1:0]  sum;
      sum = '0;
      for (int p = 0; p < DIGITS; p++) begin
         x = a[DIGIT_W*p +: DIGIT_W];
         y = b[DIGIT_W*p +: DIGIT_W];
         d = (x > y) ? (x - y) : (y - x);
         if (d > DIAL_HALF) begin
            d = DIAL - d;
         end
         sum = sum + LINK_W'(d);
      end
      return sum;
   endfunction

   // Control registers.
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              dropped_ff, dropped_in;
   logic [LINK_W-1:0] best_start_ff, best_start_in;
   logic              rd_valid_ff, rd_valid_in;

   // Payload registers.
   logic [KEY_W-1:0]  val_ff, val_in;
   logic              last_ff, last_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [BCD_W-1:0]  key_ff, key_in;
   logic [BCD_W-1:0]  start_key_ff, start_key_in;
   logic [IDX_W-1:0]  start_idx_ff, start_idx_in;
   logic [BCD_W-1:0]  pick_key_ff, pick_key_in;
   logic [IDX_W-1:0]  pick_idx_ff, pick_idx_in;
   logic              init_ff, init_in;
   logic [IDX_W-1:0]  scan_ff, scan_in;
   logic [CNT_W-1:0]  passes_ff, passes_in;
   logic [COST_W-1:0] total_ff, total_in;
   logic [LINK_W-1:0] min_cost_ff, min_cost_in;
   logic [BCD_W-1:0]  min_key_ff, min_key_in;
   logic [IDX_W-1:0]  min_idx_ff, min_idx_in;
   logic [IDX_W-1:0]  idx_b_ff, idx_b_in;

   logic [PROD_W-1:0] prod;
   logic [KEY_W-1:0]  quot;
   logic [KEY_W-1:0]  rem_wide;
   logic [LINK_W-1:0] dist0;

   logic [BCD_W-1:0]  key_rd;
   logic [LINK_W-1:0] best_rd;
   logic              tree_rd;
   logic [LINK_W-1:0] link_d;
   logic              is_pick;
   logic              tree_new;
   logic [LINK_W-1:0] best_new;
   logic              cand;

   // Division by ten through the reciprocal; exact for every 14-bit value.
   assign prod     = PROD_W'(val_ff) * PROD_W'(RECIP);
   assign quot     = KEY_W'(prod >> RECIP_SHIFT);
   assign rem_wide = val_ff - ((quot << 3) + (quot << 1));
   assign dist0    = dial_dist('0, key_ff);

   assign link_d   = dial_dist(pick_key_ff, key_rd);
   assign is_pick  = (idx_b_ff == pick_idx_ff);
   assign tree_new = init_ff ? is_pick : (tree_rd | is_pick);
   assign best_new = (init_ff || (link_d < best_rd)) ? link_d : best_rd;
   assign cand     = rd_valid_ff && !tree_new && (best_new < min_cost_ff);

   always_comb begin
      count_in      = count_ff;
      dropped_in    = dropped_ff;
      best_start_in = best_start_ff;
      rd_valid_in   = cmd.scan_issue;
      val_in        = val_ff;
      last_in       = last_ff;
      step_in       = step_ff;
      key_in        = key_ff;
      start_key_in  = start_key_ff;
      start_idx_in  = start_idx_ff;
      pick_key_in   = pick_key_ff;
      pick_idx_in   = pick_idx_ff;
      init_in       = init_ff;
      scan_in       = scan_ff;
      passes_in     = passes_ff;
      total_in      = total_ff;
      min_cost_in   = min_cost_ff;
      min_key_in    = min_key_ff;
      min_idx_in    = min_idx_ff;
      idx_b_in      = scan_ff;

      if (cmd.load) begin
         val_in  = req.key_value;
         last_in = req.last_key;
         step_in = '0;
      end
      if (cmd.drop) begin
         dropped_in = 1'b1;
      end
      if (cmd.conv_step) begin
         key_in[DIGIT_W*step_ff +: DIGIT_W] = rem_wide[DIGIT_W-1:0];
         val_in  = quot;
         step_in = step_ff + STEP_W'(1);
      end
      if (cmd.store) begin
         count_in = count_ff + CNT_W'(1);
         if (dist0 < best_start_ff) begin
            best_start_in = dist0;
            start_key_in  = key_ff;
            start_idx_in  = count_ff[IDX_W-1:0];
         end
      end
      if (cmd.compute_begin) begin
         total_in    = COST_W'(best_start_ff);
         pick_key_in = start_key_ff;
         pick_idx_in = start_idx_ff;
         init_in     = 1'b1;
         passes_in   = count_ff - CNT_W'(1);
      end
      if (cmd.scan_issue) begin
         scan_in = scan_ff + IDX_W'(1);
      end
      if (cand) begin
         min_cost_in = best_new;
         min_key_in  = key_rd;
         min_idx_in  = idx_b_ff;
      end
      if (cmd.pass_finish) begin
         total_in    = total_ff + COST_W'(min_cost_ff);
         pick_key_in = min_key_ff;
         pick_idx_in = min_idx_ff;
         init_in     = 1'b0;
         passes_in   = passes_ff - CNT_W'(1);
      end
      if (cmd.pass_begin) begin
         scan_in     = '0;
         min_cost_in = LINK_INF;
      end
      if (cmd.respond) begin
         count_in      = '0;
         dropped_in    = 1'b0;
         best_start_in = LINK_INF;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         dropped_ff    <= 1'b0;
         best_start_ff <= LINK_INF;
         rd_valid_ff   <= 1'b0;
      end else begin
         count_ff      <= count_in;
         dropped_ff    <= dropped_in;
         best_start_ff <= best_start_in;
         rd_valid_ff   <= rd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff       <= val_in;
      last_ff      <= last_in;
      step_ff      <= step_in;
      key_ff       <= key_in;
      start_key_ff <= start_key_in;
      start_idx_ff <= start_idx_in;
      pick_key_ff  <= pick_key_in;
      pick_idx_ff  <= pick_idx_in;
      init_ff      <= init_in;
      scan_ff      <= scan_in;
      passes_ff    <= passes_in;
      total_ff     <= total_in;
      min_cost_ff  <= min_cost_in;
      min_key_ff   <= min_key_in;
      min_idx_ff   <= min_idx_in;
      idx_b_ff     <= idx_b_in;
   end

   ksmsc_ram #(
      .WIDTH (BCD_W),
      .DEPTH (MAX_KEYS)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (cmd.store),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (key_ff),
      .rd_addr (scan_ff),
      .rd_data (key_rd)
   );

   ksmsc_ram #(
      .WIDTH (LINK_W),
      .DEPTH (MAX_KEYS)
   ) u_best_ram (
      .clock   (clock),
      .wr_en   (rd_valid_ff),
      .wr_addr (idx_b_ff),
      .wr_data (best_new),
      .rd_addr (scan_ff),
      .rd_data (best_rd)
   );

   ksmsc_ram #(
      .WIDTH (1),
      .DEPTH (MAX_KEYS)
   ) u_tree_ram (
      .clock   (clock),
      .wr_en   (rd_valid_ff),
      .wr_addr (idx_b_ff),
      .wr_data (tree_new),
      .rd_addr (scan_ff),
      .rd_data (tree_rd)
   );

   assign sts.full       = (count_ff == CNT_W'(MAX_KEYS));
   assign sts.digit_done = (step_ff == STEP_W'(DIGITS - 1));
   assign sts.last       = last_ff;
   assign sts.scan_last  = (CNT_W'(scan_ff) == (count_ff - CNT_W'(1)));
   assign sts.count_le1  = (count_ff <= CNT_W'(1));
   assign sts.passes_one = (passes_ff == CNT_W'(1));

   assign rsp.total_cost = total_ff;
   assign rsp.overflow   = dropped_ff;

endmodule

`default_nettype wire

>>> hw/rtl/key_set_min_spanning_cost_unit.sv
// A stored request keeps busy high for its 4 digit steps and a store; a dropped one does not, unless it is the last.
// The result strobe follows the last request once the Prim passes over the stored keys are done,
// also when that last request itself is dropped.
// Each Prim pass reads the key, cost and membership memories once per key, then drains and finishes.
// While loading, a new request is taken only once busy is low again; the receiver cannot stall the result.
// Synchronous reset idles the controller and empties the key set; memories are not cleared.
`default_nettype none

module key_set_min_spanning_cost_unit #(
   parameter int MAX_KEYS = 512
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire ksmsc_pkg::req_type req_payload,
   output logic                    rsp_valid,
   output ksmsc_pkg::rsp_type      rsp_payload
);

   import ksmsc_pkg::*;

   cmd_type cmd;
   sts_type sts;

   ksmsc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .last_key  (req_payload.last_key),
      .sts       (sts),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   ksmsc_datapath #(
      .MAX_KEYS (MAX_KEYS)
   ) u_datapath (
      .clock (clock),
      .reset (reset),
      .req   (req_payload),
      .cmd   (cmd),
      .sts   (sts),
      .rsp   (rsp_payload)
   );

endmodule

`default_nettype wire

>>> hw/rtl/ksmsc_checker.sv
`default_nettype none

module ksmsc_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               start,
   input wire logic               busy,
   input wire ksmsc_pkg::req_type req_payload,
   input wire logic               rsp_valid,
   input wire ksmsc_pkg::rsp_type rsp_payload
);

   import ksmsc_pkg::*;

   logic [COST_W-1:0] total_seen;

   assign total_seen = rsp_payload.total_cost;

   // The result strobe lasts a single cycle.
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   // The block is busy while it shows a result and idle right after.
   a_busy_on_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy ##1 !busy)
      else $error("busy does not bracket the result strobe");

   // A request that is not the last of its set never produces a result next cycle.
   a_no_early_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !req_payload.last_key) |=> !rsp_valid)
      else $error("result without a last request");

   // The last request of a set always starts work.
   a_last_starts_work: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_payload.last_key) |=> busy)
      else $error("last request did not start the computation");

   // The shown result total has no unknown bits while the strobe is high.
   a_result_known: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$isunknown(total_seen))
      else $error("result total is unknown");

endmodule

bind key_set_min_spanning_cost_unit ksmsc_checker u_checker (.*);

`default_nettype wire
